// ===== hdl/dep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dep_pkg
// Shared types and constants for the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int DEP_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int TOTAL_W      = 7;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins_en;      // insert the broadcast value
        logic shift_down;  // every entry moves one place toward cell 0
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== hdl/dep_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dep_cell
// One slot of the sorted store. Compares the broadcast value against its
// entry and takes its left neighbor's entry, the value, or its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module dep_cell
    import dep_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire                      i_clk,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire        [CNT_W-1:0]   i_count,
    input  wire signed [DATA_W-1:0]  i_value,
    input  wire signed [DATA_W-1:0]  i_left_val,
    input  wire                      i_left_gt,
    input  wire signed [DATA_W-1:0]  i_right_val,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_gt,
    output logic                     o_top
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;
    logic                     w_occ;
    logic                     w_lt;

    assign w_occ = CNT_W'(IDX) < i_count;
    assign w_lt  = i_value < r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins_en) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (!w_occ || w_lt) begin
                n_val = i_value;
            end
        end else if (i_ctrl.shift_down) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_gt  = w_occ && w_lt;
    assign o_top = w_occ && (CNT_W'(IDX + 1) == i_count);

endmodule
`default_nettype wire

// ===== hdl/double_ended_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded sorted multiset of signed values held in a row of cells.
// ----------------------------------------------------------------------------
// Throughput: 1 request per cycle while the output is not stalled; the cell
//   row and a pending flag register at accept, then the max/min select
//   runs into the output register once the output is free.
// Reset: synchronous, active low; clears the entry count and handshake
//   state. Cell contents are not reset.
// ----------------------------------------------------------------------------
module double_ended_priority_queue
    import dep_pkg::*;
#(
    parameter int CAPACITY = DEP_CAPACITY
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire        [1:0]          i_op,
    input  wire signed [DATA_W-1:0]   i_value,
    output logic                      o_valid,
    input  wire                       i_stall,
    output logic                      o_is_empty,
    output logic signed [DATA_W-1:0]  o_max_value,
    output logic signed [DATA_W-1:0]  o_min_value,
    output logic       [TOTAL_W-1:0]  o_entry_total,
    output logic                      o_overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    logic             n_pend;
    logic             r_ovf;
    logic             r_o_valid;
    logic             r_o_empty;
    logic signed [DATA_W-1:0] r_o_max;
    logic signed [DATA_W-1:0] r_o_min;
    logic [TOTAL_W-1:0]       r_o_total;
    logic             r_o_ovf;

    logic       w_in_acc;
    logic       w_out_free;
    logic       w_load;
    logic       w_full;
    logic       w_empty;
    t_op        w_op;
    t_cell_ctrl w_ctrl;

    logic signed [DATA_W-1:0] w_val [CAPACITY];
    logic                     w_gt  [CAPACITY];
    logic                     w_top [CAPACITY];
    logic signed [DATA_W-1:0] w_max;

    assign w_op       = t_op'(i_op);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_load     = r_pend && w_out_free;
    assign o_stall    = r_pend && !w_out_free;
    assign w_in_acc   = i_valid && !o_stall;
    assign n_pend     = w_in_acc || (r_pend && !w_load);

    always_comb begin
        w_ctrl  = '0;
        n_count = r_count;
        if (w_in_acc) begin
            case (w_op)
                OP_INSERT: begin
                    if (!w_full) begin
                        w_ctrl.ins_en = 1'b1;
                        n_count       = r_count + CNT_W'(1);
                    end
                end
                OP_DEL_MAX: begin
                    if (!w_empty) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_DEL_MIN: begin
                    if (!w_empty) begin
                        w_ctrl.shift_down = 1'b1;
                        n_count           = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_count = '0;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [DATA_W-1:0] w_left_val;
            logic                     w_left_gt;
            logic signed [DATA_W-1:0] w_right_val;

            if (gi == 0) begin : g_first
                assign w_left_val = i_value;
                assign w_left_gt  = 1'b0;
            end else begin : g_mid
                assign w_left_val = w_val[gi-1];
                assign w_left_gt  = w_gt[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_val = w_val[gi];
            end else begin : g_inner
                assign w_right_val = w_val[gi+1];
            end

            dep_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_count     (r_count),
                .i_value     (i_value),
                .i_left_val  (w_left_val),
                .i_left_gt   (w_left_gt),
                .i_right_val (w_right_val),
                .o_val       (w_val[gi]),
                .o_gt        (w_gt[gi]),
                .o_top       (w_top[gi])
            );
        end
    endgenerate

    // top-of-set flags are one-hot (or all clear when empty)
    always_comb begin
        w_max = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_max = w_max | (w_top[i] ? w_val[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ovf <= (w_op == OP_INSERT) && w_full;
        end
        if (w_load) begin
            r_o_empty <= w_empty;
            r_o_max   <= w_max;
            r_o_min   <= w_empty ? '0 : w_val[0];
            r_o_total <= TOTAL_W'(r_count);
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_is_empty    = r_o_empty;
    assign o_max_value   = r_o_max;
    assign o_min_value   = r_o_min;
    assign o_entry_total = r_o_total;
    assign o_overflow    = r_o_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_ovf |-> w_full)
        else $error("overflow flagged while store not full");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && (r_count >= CNT_W'(2)) |-> (w_val[0] <= w_max))
        else $error("minimum above maximum in sorted row");

endmodule
`default_nettype wire
